### hw/rtl/stat_pkg.sv
// ----------------------------------------------------------------------------
// stat_pkg: shared types and helpers for the section table translator
// Query beat layout, table entry layout, operation and class codes.
// ----------------------------------------------------------------------------
package stat_pkg;

  localparam int STAT_MAX_SECTIONS = 16;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_V2F      = 2'd1,
    OP_F2V      = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_t;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_CODE = 2'd1;
  localparam logic [1:0] CLASS_DATA = 2'd2;

  localparam logic [1:0] CFG_SECTION_COUNT = 2'd0;
  localparam logic [1:0] CFG_FILE_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_CODE_MASK     = 2'd2;

  localparam logic [31:0] CODE_MASK_RESET = 32'd32;

  // One table entry, with range ends and the offset delta worked out on write
  typedef struct packed {
    logic [31:0] vaddr;
    logic [31:0] fileptr;
    logic [32:0] hi_v;
    logic [32:0] hi_f;
    logic [31:0] delta;
    logic [31:0] flags;
    logic [63:0] name;
  } entry_t;

  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    entry_t      entry;
  } wr_t;

  typedef struct packed {
    logic [4:0]  section_count;
    logic [31:0] code_flag_mask;
  } cell_cfg_t;

  // Query beat walking down the chain
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] addr;
    logic        done;
    logic [31:0] translated;
    logic [32:0] reg_start;
    logic [32:0] reg_end;
    logic [1:0]  cls;
    logic [4:0]  num;
    logic [63:0] name;
  } token_t;

  // Keep name bytes up to the first zero byte, clear the rest
  function automatic logic [63:0] clean_name(input logic [63:0] raw);
    logic [63:0] res;
    logic        keep;
    res  = '0;
    keep = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        keep = 1'b0;
      end
      if (keep) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/section_table_address_translator.sv
// ----------------------------------------------------------------------------
// section_table_address_translator: section table lookup and classification
// Virtual/file offset translation and file offset classification over a
// table of sections held in a chain of cells.
// ----------------------------------------------------------------------------
// Result path: a query beat passes through the registers of the cell chain and
//   then the result register; an entry write gives its (all zero) result in the cycle after accept.
// Flow: one beat at a time; a new beat is taken only after the last result beat
//   is taken, while a query walks the cell chain, one table entry per cell.
// Reset: clears section_count and file_length, sets code_flag_mask to 32 and
//   empties the chain; table entries stay undefined until written.
module section_table_address_translator
  import stat_pkg::*;
#(
  parameter int MAX_SECTIONS = STAT_MAX_SECTIONS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  entry_index,
  input  logic [31:0] query_addr,
  input  logic [31:0] entry_vaddr,
  input  logic [31:0] entry_size,
  input  logic [31:0] entry_fileptr,
  input  logic [31:0] entry_flags,
  input  logic [63:0] entry_name,
  // result beat
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] translated,
  output logic [4:0]  section_number,
  output logic [31:0] region_start,
  output logic [31:0] region_end,
  output logic [1:0]  region_class,
  output logic [63:0] section_name
);

  // Configuration registers
  logic [4:0]  section_count;
  logic [31:0] file_length;
  logic [31:0] code_flag_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count  <= '0;
      file_length    <= '0;
      code_flag_mask <= CODE_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SECTION_COUNT: section_count  <= cfg_data[4:0];
        CFG_FILE_LENGTH:   file_length    <= cfg_data;
        CFG_CODE_MASK:     code_flag_mask <= cfg_data;
        default:           ;  // index beyond the register list: drop
      endcase
    end
  end

  // Handshake: one beat in the block at a time, from accept until its result
  // beat is taken
  op_t  in_op;
  logic accept;
  logic wr_accept;
  logic busy;
  logic out_take;

  assign in_op     = op_t'(op);
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign wr_accept = accept && (in_op == OP_WRITE);
  assign out_take  = out_valid && out_ready;

  // Entry write: broadcast to every cell, the addressed one captures it.
  // Range ends and the translation delta are worked out here once.
  wr_t       wr;
  cell_cfg_t cell_cfg;

  always_comb begin
    wr.en            = wr_accept;
    wr.index         = entry_index;
    wr.entry.vaddr   = entry_vaddr;
    wr.entry.fileptr = entry_fileptr;
    wr.entry.hi_v    = {1'b0, entry_vaddr} + {1'b0, entry_size};
    wr.entry.hi_f    = {1'b0, entry_fileptr} + {1'b0, entry_size};
    wr.entry.delta   = entry_fileptr - entry_vaddr;
    wr.entry.flags   = entry_flags;
    wr.entry.name    = clean_name(entry_name);
  end

  assign cell_cfg.section_count  = section_count;
  assign cell_cfg.code_flag_mask = code_flag_mask;

  // Query beat entering the chain
  token_t tok_head;

  always_comb begin
    tok_head       = '0;
    tok_head.valid = accept && (in_op != OP_WRITE);
    tok_head.op    = in_op;
    tok_head.addr  = query_addr;
  end

  // Cell chain: cell k holds entry k and hands the query beat on each cycle
  token_t                  tok_chain [MAX_SECTIONS+1];
  logic [MAX_SECTIONS:0]   chain_valid;

  assign tok_chain[0] = tok_head;

  for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
    stat_cell #(
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr),
      .cfg     (cell_cfg),
      .tok_in  (tok_chain[k]),
      .tok_out (tok_chain[k+1])
    );
  end

  for (genvar k = 0; k <= MAX_SECTIONS; k++) begin : g_valid
    assign chain_valid[k] = tok_chain[k].valid;
  end

  token_t tok_last;
  logic   is_class;

  assign tok_last = tok_chain[MAX_SECTIONS];
  assign is_class = (tok_last.op == OP_CLASSIFY);

  // Control of the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (out_take) begin
        busy      <= 1'b0;
        out_valid <= 1'b0;
      end
      if (wr_accept || tok_last.valid) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Result payload: a write gives all zeros; a classify query that ran off the end of
  // the table without a hit takes file_length as its region end
  always_ff @(posedge clk) begin
    if (wr_accept) begin
      translated     <= '0;
      section_number <= '0;
      region_start   <= '0;
      region_end     <= '0;
      region_class   <= CLASS_NONE;
      section_name   <= '0;
    end else if (tok_last.valid) begin
      translated     <= tok_last.translated;
      section_number <= tok_last.num;
      region_start   <= tok_last.reg_start[31:0];
      region_end     <= !is_class      ? 32'd0 :
                        tok_last.done  ? tok_last.reg_end[31:0] : file_length;
      region_class   <= tok_last.cls;
      section_name   <= tok_last.name;
    end
  end

  // Checks
  a_one_beat_in_chain: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_valid) <= 1)
    else $error("more than one query beat in the cell chain");

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result beat is pending");

  a_chain_end_clear: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> (busy && !out_valid))
    else $error("query beat left the chain with the result register full");

  a_gap_has_no_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && section_number == 5'd0) |-> (region_class == CLASS_NONE))
    else $error("gap or miss reported with a section class");

endmodule

### hw/rtl/stat_cell.sv
// ----------------------------------------------------------------------------
// stat_cell: one section table entry and its match stage
// Holds one entry, checks the passing query beat against it, registers it on.
// ----------------------------------------------------------------------------
module stat_cell
  import stat_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  wr_t       wr,
  input  cell_cfg_t cfg,
  input  token_t    tok_in,
  output token_t    tok_out
);

  localparam logic [4:0] NUM = 5'(IDX + 1);

  entry_t ent;
  token_t tok_next;
  logic   active;
  logic   wr_hit;
  logic [32:0] addr_w;

  assign wr_hit = wr.en && (IDX < 16) && (32'(wr.index) == IDX);
  assign active = 32'(cfg.section_count) > IDX;
  assign addr_w = {1'b0, tok_in.addr};

  // Entry contents: no reset, undefined until written
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      ent <= wr.entry;
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.done && active) begin
      unique case (tok_in.op)
        OP_V2F: begin
          if (addr_w >= {1'b0, ent.vaddr} && addr_w <= ent.hi_v) begin
            tok_next.translated = tok_in.addr + ent.delta;
            tok_next.done       = 1'b1;
          end
        end
        OP_F2V: begin
          if (addr_w >= {1'b0, ent.fileptr} && addr_w <= ent.hi_f) begin
            tok_next.translated = tok_in.addr - ent.delta;
            tok_next.done       = 1'b1;
          end
        end
        OP_CLASSIFY: begin
          if (addr_w >= tok_in.reg_start && addr_w < {1'b0, ent.fileptr}) begin
            // gap before this section
            tok_next.reg_end = {1'b0, ent.fileptr};
            tok_next.done    = 1'b1;
          end else if (addr_w >= {1'b0, ent.fileptr} && addr_w < ent.hi_f) begin
            tok_next.reg_start = {1'b0, ent.fileptr};
            tok_next.reg_end   = ent.hi_f;
            tok_next.cls       = ((ent.flags & cfg.code_flag_mask) == cfg.code_flag_mask)
                                 ? CLASS_CODE : CLASS_DATA;
            tok_next.num       = NUM;
            tok_next.name      = ent.name;
            tok_next.done      = 1'b1;
          end else begin
            tok_next.reg_start = ent.hi_f;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule
